/* rtl/wcmm_pkg.sv */
// Types, constants and helper functions shared by the windowed channel min/max unit.
package wcmm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CH_IDX_W    = 6;
    localparam int NC_W        = 7;
    localparam int SPC_W       = 13;
    localparam int WB_W        = 6;
    localparam int MAX_SAMPLES = 4096;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    typedef logic signed [SAMPLE_W-1:0] smp_t;

    localparam smp_t SMP_MAX = smp_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam smp_t SMP_MIN = smp_t'({1'b1, {(SAMPLE_W-1){1'b0}}});

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_NUM_CHANNELS        = 2'd0;
    localparam reg_idx_t REG_SAMPLES_PER_CHANNEL = 2'd1;
    localparam reg_idx_t REG_WINDOW_BUFFERS      = 2'd2;

    typedef struct packed {
        smp_t sample_value;
    } sample_item_t;

    typedef struct packed {
        logic [CH_IDX_W-1:0] channel_index;
        smp_t                block_min;
        smp_t                block_max;
        smp_t                window_min;
        smp_t                window_max;
        smp_t                total_min;
        smp_t                total_max;
        smp_t                global_window_min;
        smp_t                global_window_max;
        logic                block_done;
    } result_item_t;

    typedef struct packed {
        logic [NC_W-1:0]  num_channels;
        logic [SPC_W-1:0] samples_per_channel;
        logic [WB_W-1:0]  window_buffers;
    } cfg_t;

    typedef struct packed {
        logic            num_channels_wr;
        logic            samples_per_channel_wr;
        logic            window_buffers_wr;
        logic [WB_W-1:0] window_buffers_new;
    } cfg_wr_t;

    typedef struct packed {
        smp_t lo;
        smp_t hi;
    } pair_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WALK,
        ST_DRAIN
    } wcmm_state_t;

    function automatic smp_t smp_min(smp_t a, smp_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic smp_t smp_max(smp_t a, smp_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* rtl/wcmm_stream_if.sv */
// Valid/ready stream interface carrying one payload item per transaction.
interface wcmm_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* rtl/wcmm_ring.sv */
// Extremes ring memory: one write port, one read port with registered read data.
module wcmm_ring #(
    parameter int DEPTH = 2048
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wcmm_pkg::pair_t                   wr_data,
    input  logic                              rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output wcmm_pkg::pair_t                   rd_data
);
    import wcmm_pkg::*;

    pair_t mem [DEPTH];
    pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/wcmm_cfg.sv */
// APB-style configuration registers with range saturation and write strobes.
module wcmm_cfg #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_BUFFERS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [wcmm_pkg::PDATA_W-1:0]   pwdata,
    output logic [wcmm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output wcmm_pkg::cfg_t                 cfg,
    output wcmm_pkg::cfg_wr_t              cfg_wr
);
    import wcmm_pkg::*;

    reg_idx_t         idx;
    logic             wr_hit;
    logic [NC_W-1:0]  nc_raw;
    logic [SPC_W-1:0] spc_raw;
    logic [WB_W-1:0]  wb_raw;
    logic [NC_W-1:0]  nc_new;
    logic [SPC_W-1:0] spc_new;
    logic [WB_W-1:0]  wb_new;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;

    assign pready  = 1'b1;
    assign idx     = paddr[PADDR_W-1:2];
    assign wr_hit  = psel & penable & pwrite & pready;
    assign nc_raw  = pwdata[NC_W-1:0];
    assign spc_raw = pwdata[SPC_W-1:0];
    assign wb_raw  = pwdata[WB_W-1:0];

    assign nc_new  = (nc_raw == '0) ? NC_W'(1) :
                     (32'(nc_raw) > MAX_CHANNELS) ? NC_W'(MAX_CHANNELS) : nc_raw;
    assign spc_new = (spc_raw == '0) ? SPC_W'(1) :
                     (32'(spc_raw) > MAX_SAMPLES) ? SPC_W'(MAX_SAMPLES) : spc_raw;
    assign wb_new  = (wb_raw == '0) ? WB_W'(1) :
                     (32'(wb_raw) > MAX_BUFFERS) ? WB_W'(MAX_BUFFERS) : wb_raw;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_wr   = '0;
        cfg_wr.window_buffers_new = wb_new;
        if (wr_hit)
        begin
            case (idx)
                REG_NUM_CHANNELS:
                begin
                    cfg_next.num_channels = nc_new;
                    cfg_wr.num_channels_wr = 1'b1;
                end
                REG_SAMPLES_PER_CHANNEL:
                begin
                    cfg_next.samples_per_channel = spc_new;
                    cfg_wr.samples_per_channel_wr = 1'b1;
                end
                REG_WINDOW_BUFFERS:
                begin
                    cfg_next.window_buffers = wb_new;
                    cfg_wr.window_buffers_wr = 1'b1;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_NUM_CHANNELS:        prdata = PDATA_W'(cfg_reg.num_channels);
            REG_SAMPLES_PER_CHANNEL: prdata = PDATA_W'(cfg_reg.samples_per_channel);
            REG_WINDOW_BUFFERS:      prdata = PDATA_W'(cfg_reg.window_buffers);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels        <= NC_W'(1);
            cfg_reg.samples_per_channel <= SPC_W'(1);
            cfg_reg.window_buffers      <= WB_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/windowed_channel_min_max_unit.sv */
// Windowed channel min/max unit: top level with sample counters, window walk and result register.
// Samples are taken one per cycle while a channel run is in progress. At the last sample of a
// channel the block extremes are written to the extremes ring and the older blocks still in the
// window are read back one ring read per cycle with the input held off; the window holds
// min(blocks_stored + 1, window_buffers) blocks, and with one block no read or hold-off follows;
// a channel end also waits while the previous result has not been taken. The ring memory has no
// clearing pass: an entry is only read after it has been written, so the block is ready at reset.
module windowed_channel_min_max_unit #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_BUFFERS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    wcmm_stream_if.sink                    samples,
    wcmm_stream_if.source                  results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [wcmm_pkg::PDATA_W-1:0]   pwdata,
    output logic [wcmm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import wcmm_pkg::*;

    localparam int DEPTH  = MAX_BUFFERS * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;

    cfg_t              cfg;
    cfg_wr_t           cfg_wr;

    wcmm_state_t       state_reg, state_next;
    logic [SPC_W-1:0]  sample_count_reg, sample_count_next;
    logic [CH_W-1:0]   channel_count_reg, channel_count_next;
    logic [SLOT_W-1:0] ring_slot_reg, ring_slot_next;
    logic [WB_W-1:0]   blocks_stored_reg, blocks_stored_next;
    smp_t              run_min_reg, run_min_next;
    smp_t              run_max_reg, run_max_next;
    smp_t              all_min_reg, all_min_next;
    smp_t              all_max_reg, all_max_next;
    smp_t              bg_min_reg, bg_min_next;
    smp_t              bg_max_reg, bg_max_next;
    logic [SLOT_W-1:0] walk_slot_reg, walk_slot_next;
    logic [CH_W-1:0]   walk_ch_reg, walk_ch_next;
    logic [WB_W-1:0]   walk_left_reg, walk_left_next;
    result_item_t      hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;
    result_item_t      out_data_reg, out_data_next;
    logic              rvalid_reg;

    smp_t              smp;
    smp_t              rmin, rmax, amin, amax;
    logic [SPC_W-1:0]  sc_inc;
    logic              last_sample;
    logic [CH_W:0]     ch_inc;
    logic              ch_done;
    logic [WB_W-1:0]   wb_m1;
    logic [WB_W-1:0]   walk_count;
    logic              in_ready;
    logic              accept;
    smp_t              fold_min, fold_max;
    smp_t              g_min, g_max;
    result_item_t      item_now;
    result_item_t      fin_item;
    logic              fin_valid;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pair_t             wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    pair_t             rd_data;

    wcmm_cfg #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BUFFERS  (MAX_BUFFERS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    wcmm_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [SLOT_W-1:0] slot_dec(logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(MAX_BUFFERS - 1) : s - SLOT_W'(1);
    endfunction

    assign smp         = samples.data.sample_value;
    assign rmin        = smp_min(run_min_reg, smp);
    assign rmax        = smp_max(run_max_reg, smp);
    assign amin        = smp_min(all_min_reg, smp);
    assign amax        = smp_max(all_max_reg, smp);
    assign sc_inc      = sample_count_reg + SPC_W'(1);
    assign last_sample = (sc_inc >= cfg.samples_per_channel);
    assign ch_inc      = {1'b0, channel_count_reg} + (CH_W+1)'(1);
    assign ch_done     = (32'(ch_inc) >= 32'(cfg.num_channels));
    assign wb_m1       = cfg.window_buffers - WB_W'(1);
    assign walk_count  = (blocks_stored_reg < wb_m1) ? blocks_stored_reg : wb_m1;

    assign in_ready       = (state_reg == ST_RUN) && !(last_sample && out_valid_reg);
    assign samples.ready  = in_ready;
    assign accept         = samples.valid && in_ready;

    assign fold_min = rvalid_reg ? smp_min(hold_reg.window_min, rd_data.lo) : hold_reg.window_min;
    assign fold_max = rvalid_reg ? smp_max(hold_reg.window_max, rd_data.hi) : hold_reg.window_max;

    assign wr_addr = ADDR_W'(ADDR_W'(ring_slot_reg) * ADDR_W'(MAX_CHANNELS))
                     + ADDR_W'(channel_count_reg);
    assign rd_addr = ADDR_W'(ADDR_W'(walk_slot_reg) * ADDR_W'(MAX_CHANNELS))
                     + ADDR_W'(walk_ch_reg);
    assign wr_data = '{lo: rmin, hi: rmax};

    always_comb
    begin
        item_now                   = '0;
        item_now.channel_index     = CH_IDX_W'(channel_count_reg);
        item_now.block_min         = rmin;
        item_now.block_max         = rmax;
        item_now.window_min        = rmin;
        item_now.window_max        = rmax;
        item_now.total_min         = amin;
        item_now.total_max         = amax;
        item_now.block_done        = ch_done;
    end

    always_comb
    begin
        state_next         = state_reg;
        sample_count_next  = sample_count_reg;
        channel_count_next = channel_count_reg;
        ring_slot_next     = ring_slot_reg;
        blocks_stored_next = blocks_stored_reg;
        run_min_next       = run_min_reg;
        run_max_next       = run_max_reg;
        all_min_next       = all_min_reg;
        all_max_next       = all_max_reg;
        bg_min_next        = bg_min_reg;
        bg_max_next        = bg_max_reg;
        walk_slot_next     = walk_slot_reg;
        walk_ch_next       = walk_ch_reg;
        walk_left_next     = walk_left_reg;
        hold_next          = hold_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        fin_valid          = 1'b0;
        fin_item           = hold_reg;
        fin_item.window_min = fold_min;
        fin_item.window_max = fold_max;
        g_min              = bg_min_reg;
        g_max              = bg_max_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    all_min_next = amin;
                    all_max_next = amax;
                    if (last_sample)
                    begin
                        sample_count_next = '0;
                        run_min_next      = SMP_MAX;
                        run_max_next      = SMP_MIN;
                        wr_en             = 1'b1;
                        hold_next         = item_now;
                        if (ch_done)
                        begin
                            channel_count_next = '0;
                            ring_slot_next = (ring_slot_reg == SLOT_W'(MAX_BUFFERS - 1)) ?
                                             '0 : ring_slot_reg + SLOT_W'(1);
                            blocks_stored_next =
                                ((blocks_stored_reg + WB_W'(1)) < cfg.window_buffers) ?
                                blocks_stored_reg + WB_W'(1) : wb_m1;
                        end
                        else
                        begin
                            channel_count_next = ch_inc[CH_W-1:0];
                        end
                        if (walk_count == '0)
                        begin
                            fin_valid = 1'b1;
                            fin_item  = item_now;
                        end
                        else
                        begin
                            walk_slot_next = slot_dec(ring_slot_reg);
                            walk_ch_next   = channel_count_reg;
                            walk_left_next = walk_count;
                            state_next     = ST_WALK;
                        end
                    end
                    else
                    begin
                        sample_count_next = sc_inc;
                        run_min_next      = rmin;
                        run_max_next      = rmax;
                    end
                end
            end
            ST_WALK:
            begin
                rd_en                = 1'b1;
                walk_slot_next       = slot_dec(walk_slot_reg);
                walk_left_next       = walk_left_reg - WB_W'(1);
                hold_next.window_min = fold_min;
                hold_next.window_max = fold_max;
                if (walk_left_reg == WB_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                fin_valid  = 1'b1;
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (fin_valid)
        begin
            g_min = smp_min(bg_min_reg, fin_item.window_min);
            g_max = smp_max(bg_max_reg, fin_item.window_max);
            if (fin_item.block_done)
            begin
                fin_item.global_window_min = g_min;
                fin_item.global_window_max = g_max;
                bg_min_next = SMP_MAX;
                bg_max_next = SMP_MIN;
            end
            else
            begin
                fin_item.global_window_min = '0;
                fin_item.global_window_max = '0;
                bg_min_next = g_min;
                bg_max_next = g_max;
            end
            out_valid_next = 1'b1;
            out_data_next  = fin_item;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        // restart the block on a shape change; shrink the window on a smaller buffer count
        if (cfg_wr.num_channels_wr || cfg_wr.samples_per_channel_wr)
        begin
            channel_count_next = '0;
            sample_count_next  = '0;
            run_min_next       = SMP_MAX;
            run_max_next       = SMP_MIN;
            bg_min_next        = SMP_MAX;
            bg_max_next        = SMP_MIN;
        end
        if (cfg_wr.num_channels_wr)
        begin
            blocks_stored_next = '0;
        end
        if (cfg_wr.window_buffers_wr &&
            (blocks_stored_reg > (cfg_wr.window_buffers_new - WB_W'(1))))
        begin
            blocks_stored_next = cfg_wr.window_buffers_new - WB_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RUN;
            sample_count_reg  <= '0;
            channel_count_reg <= '0;
            ring_slot_reg     <= '0;
            blocks_stored_reg <= '0;
            run_min_reg       <= SMP_MAX;
            run_max_reg       <= SMP_MIN;
            all_min_reg       <= SMP_MAX;
            all_max_reg       <= SMP_MIN;
            bg_min_reg        <= SMP_MAX;
            bg_max_reg        <= SMP_MIN;
            walk_left_reg     <= '0;
            out_valid_reg     <= 1'b0;
            rvalid_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sample_count_reg  <= sample_count_next;
            channel_count_reg <= channel_count_next;
            ring_slot_reg     <= ring_slot_next;
            blocks_stored_reg <= blocks_stored_next;
            run_min_reg       <= run_min_next;
            run_max_reg       <= run_max_next;
            all_min_reg       <= all_min_next;
            all_max_reg       <= all_max_next;
            bg_min_reg        <= bg_min_next;
            bg_max_reg        <= bg_max_next;
            walk_left_reg     <= walk_left_next;
            out_valid_reg     <= out_valid_next;
            rvalid_reg        <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_slot_reg <= walk_slot_next;
        walk_ch_reg   <= walk_ch_next;
        hold_reg      <= hold_next;
        out_data_reg  <= out_data_next;
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    a_sample_count_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        sample_count_reg < cfg.samples_per_channel)
        else $error("sample position beyond the channel run");

    a_channel_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        32'(channel_count_reg) < 32'(cfg.num_channels))
        else $error("channel position beyond the block");

    a_window_fill: assert property (@(posedge clk) disable iff (!rst_n)
        blocks_stored_reg < cfg.window_buffers)
        else $error("stored blocks exceed the window");

    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> rvalid_reg)
        else $error("last window read missing at drain");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid |-> !out_valid_reg)
        else $error("result register loaded while still full");

endmodule

/* test/tb_windowed_channel_min_max_unit.sv */
// Testbench for the windowed channel min/max unit: directed and random sample traffic checked against a predictor.
module tb_windowed_channel_min_max_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wcmm_pkg::*;

    localparam int CHAN_LIMIT    = 64;
    localparam int BUF_LIMIT     = 32;
    localparam int SETTLE_CYCLES = 40;

    localparam reg_idx_t REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    wcmm_stream_if #(.payload_t(sample_item_t)) sample_bus ();
    wcmm_stream_if #(.payload_t(result_item_t)) result_bus ();

    windowed_channel_min_max_unit #(
        .MAX_CHANNELS(CHAN_LIMIT),
        .MAX_BUFFERS (BUF_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_bus.sink),
        .results(result_bus.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pair_t        win_ring [BUF_LIMIT][CHAN_LIMIT];
    int unsigned  fill_slot;
    int unsigned  kept_blocks;
    int unsigned  chan_pos;
    int unsigned  run_pos;
    smp_t         chan_lo;
    smp_t         chan_hi;
    smp_t         seen_lo;
    smp_t         seen_hi;
    smp_t         frame_lo;
    smp_t         frame_hi;
    int unsigned  cfg_nc;
    int unsigned  cfg_spc;
    int unsigned  cfg_wb;

    result_item_t pending_reports [$];
    int           error_count;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           stall_request;

    function automatic void restart_frame();
        chan_pos = 0;
        run_pos  = 0;
        chan_lo  = SMP_MAX;
        chan_hi  = SMP_MIN;
        frame_lo = SMP_MAX;
        frame_hi = SMP_MIN;
    endfunction

    function automatic void reset_tracker();
        fill_slot   = 0;
        kept_blocks = 0;
        restart_frame();
        seen_lo = SMP_MAX;
        seen_hi = SMP_MIN;
        cfg_nc  = 1;
        cfg_spc = 1;
        cfg_wb  = 1;
    endfunction

    function automatic int unsigned clamp_field(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void mirror_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
        case (idx)
            REG_NUM_CHANNELS:
            begin
                cfg_nc      = clamp_field(32'(value[NC_W-1:0]), CHAN_LIMIT);
                kept_blocks = 0;
                restart_frame();
            end
            REG_SAMPLES_PER_CHANNEL:
            begin
                cfg_spc = clamp_field(32'(value[SPC_W-1:0]), MAX_SAMPLES);
                restart_frame();
            end
            REG_WINDOW_BUFFERS:
            begin
                cfg_wb = clamp_field(32'(value[WB_W-1:0]), BUF_LIMIT);
                if (kept_blocks > cfg_wb - 1)
                    kept_blocks = cfg_wb - 1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void track_sample(smp_t s);
        result_item_t r;
        int unsigned  ch;
        int unsigned  n;
        int unsigned  k;
        int unsigned  slot;
        smp_t         wlo;
        smp_t         whi;
        logic         done;
        if (s < chan_lo) chan_lo = s;
        if (s > chan_hi) chan_hi = s;
        if (s < seen_lo) seen_lo = s;
        if (s > seen_hi) seen_hi = s;
        run_pos++;
        if (run_pos < cfg_spc)
            return;
        run_pos = 0;
        ch = chan_pos % CHAN_LIMIT;
        win_ring[fill_slot][ch] = '{lo: chan_lo, hi: chan_hi};
        n = kept_blocks + 1;
        if (n > cfg_wb)
            n = cfg_wb;
        wlo = SMP_MAX;
        whi = SMP_MIN;
        for (k = 0; k < n; k++)
        begin
            slot = (fill_slot + BUF_LIMIT - k) % BUF_LIMIT;
            if (win_ring[slot][ch].lo < wlo) wlo = win_ring[slot][ch].lo;
            if (win_ring[slot][ch].hi > whi) whi = win_ring[slot][ch].hi;
        end
        if (wlo < frame_lo) frame_lo = wlo;
        if (whi > frame_hi) frame_hi = whi;
        done = (ch + 1 >= cfg_nc);

        r.channel_index     = CH_IDX_W'(ch);
        r.block_min         = chan_lo;
        r.block_max         = chan_hi;
        r.window_min        = wlo;
        r.window_max        = whi;
        r.total_min         = seen_lo;
        r.total_max         = seen_hi;
        r.global_window_min = done ? frame_lo : '0;
        r.global_window_max = done ? frame_hi : '0;
        r.block_done        = done;
        pending_reports = {pending_reports, r};

        chan_lo = SMP_MAX;
        chan_hi = SMP_MIN;
        if (done)
        begin
            chan_pos  = 0;
            fill_slot = (fill_slot + 1) % BUF_LIMIT;
            if (kept_blocks + 1 < cfg_wb)
                kept_blocks++;
            else
                kept_blocks = cfg_wb - 1;
            frame_lo = SMP_MAX;
            frame_hi = SMP_MIN;
        end
        else
            chan_pos = ch + 1;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_report(result_item_t got);
        result_item_t want;
        if (pending_reports.size() == 0)
        begin
            $error("result with nothing pending, channel_index %0d", got.channel_index);
            error_count++;
        end
        else
        begin
            want = pending_reports[0];
            pending_reports.delete(0);
            check_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
            check_field("block_min", 32'(want.block_min), 32'(got.block_min));
            check_field("block_max", 32'(want.block_max), 32'(got.block_max));
            check_field("window_min", 32'(want.window_min), 32'(got.window_min));
            check_field("window_max", 32'(want.window_max), 32'(got.window_max));
            check_field("total_min", 32'(want.total_min), 32'(got.total_min));
            check_field("total_max", 32'(want.total_max), 32'(got.total_max));
            check_field("global_window_min", 32'(want.global_window_min),
                        32'(got.global_window_min));
            check_field("global_window_max", 32'(want.global_window_max),
                        32'(got.global_window_max));
            check_field("block_done", 32'(want.block_done), 32'(got.block_done));
        end
    endtask

    always @(posedge clk)
    begin
        if (sample_bus.valid && sample_bus.ready)
            track_sample(sample_bus.data.sample_value);
        if (result_bus.valid && result_bus.ready)
            check_report(result_bus.data);
    end

    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                hold = stall_request;
                stall_request = 0;
                repeat (hold)
                begin
                    result_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic set_idling(int src_pct, int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
    endtask

    task automatic push_sample(smp_t v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid             <= 1'b1;
        sample_bus.data.sample_value <= v;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
    endtask

    task automatic await_idle();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_register(idx, value);
        @(posedge clk);
    endtask

    function automatic smp_t pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return SMP_MAX;
        if (sel == 1)
            return SMP_MIN;
        if (sel < 4)
            return smp_t'(int'($urandom_range(200)) - 100);
        return smp_t'($urandom);
    endfunction

    function automatic logic [PDATA_W-1:0] pick_config(reg_idx_t idx);
        logic [PDATA_W-1:0] v;
        int                 sel;
        int                 w;
        sel = $urandom_range(9);
        case (idx)
            REG_NUM_CHANNELS:
            begin
                w = NC_W;
                if (sel < 7)       v = $urandom_range(1, 4);
                else if (sel == 7) v = $urandom_range(5, CHAN_LIMIT - 1);
                else if (sel == 8) v = CHAN_LIMIT;
                else               v = $urandom_range(1) ? 0 : $urandom_range(CHAN_LIMIT + 1, 127);
            end
            REG_SAMPLES_PER_CHANNEL:
            begin
                w = SPC_W;
                if (sel < 8)       v = $urandom_range(1, 3);
                else if (sel == 8) v = $urandom_range(4, 12);
                else               v = 0;
            end
            default:
            begin
                w = WB_W;
                if (sel < 4)       v = $urandom_range(1, 4);
                else if (sel < 8)  v = $urandom_range(5, BUF_LIMIT);
                else if (sel == 8) v = BUF_LIMIT;
                else               v = $urandom_range(1) ? 0 : $urandom_range(BUF_LIMIT + 1, 63);
            end
        endcase
        if ($urandom_range(3) == 0)
            v = v | ($urandom << w);
        return v;
    endfunction

    task automatic test_reset_state();
        await_idle();
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(smp_t'(0));
        push_sample(smp_t'(-1));
    endtask

    task automatic test_register_saturation();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'h0000_0080);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'h0000_2000);
        write_register(REG_WINDOW_BUFFERS, 32'h0000_0040);
        write_register(REG_UNUSED, $urandom);
        push_sample(pick_sample());
        push_sample(pick_sample());
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'hFFFF_FF82);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'h0000_2002);
        write_register(REG_WINDOW_BUFFERS, 32'h0000_00C3);
        repeat (4) push_sample(pick_sample());
    endtask

    task automatic test_shape_restart();
        repeat (3) push_sample(pick_sample());
        await_idle();
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd1);
        push_sample(pick_sample());
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd2);
        repeat (2) push_sample(pick_sample());
    endtask

    task automatic test_window_shrink();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd1);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd1);
        write_register(REG_WINDOW_BUFFERS, 32'd8);
        repeat (6) push_sample(pick_sample());
        await_idle();
        write_register(REG_WINDOW_BUFFERS, 32'd2);
        repeat (2) push_sample(pick_sample());
    endtask

    task automatic test_full_width_block();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd100);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd1);
        write_register(REG_WINDOW_BUFFERS, 32'd63);
        repeat (2 * CHAN_LIMIT) push_sample(pick_sample());
    endtask

    task automatic test_ring_wrap();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd1);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd1);
        write_register(REG_WINDOW_BUFFERS, BUF_LIMIT);
        repeat (BUF_LIMIT + 8) push_sample(pick_sample());
    endtask

    task automatic test_long_channel();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd1);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'h0000_1FFF);
        write_register(REG_WINDOW_BUFFERS, 32'd2);
        repeat (100) push_sample(pick_sample());
        await_idle();
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd100);
        repeat (100) push_sample(pick_sample());
    endtask

    task automatic test_backpressure();
        await_idle();
        write_register(REG_NUM_CHANNELS, 32'd4);
        write_register(REG_SAMPLES_PER_CHANNEL, 32'd1);
        write_register(REG_WINDOW_BUFFERS, 32'd8);
        stall_request = 300;
        repeat (120) push_sample(pick_sample());
        await_idle();
        repeat (40) push_sample(pick_sample());
    endtask

    task automatic test_random_traffic(int items);
        int       sent;
        int       burst;
        int       start;
        int       k;
        reg_idx_t idx;
        sent = 0;
        while (sent < items)
        begin
            await_idle();
            start = $urandom_range(2);
            for (k = 0; k < 3; k++)
            begin
                idx = reg_idx_t'((start + k) % 3);
                if ($urandom_range(2) != 0)
                    write_register(idx, pick_config(idx));
            end
            burst = $urandom_range(20, 80);
            repeat (burst) push_sample(pick_sample());
            sent += burst;
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        sample_bus.valid        = 1'b0;
        sample_bus.data         = '0;
        result_bus.ready        = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        error_count             = 0;
        stall_request           = 0;
        reset_tracker();
        set_idling(31, 69);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_saturation();
        test_shape_restart();
        test_window_shrink();
        test_full_width_block();
        test_random_traffic(80);

        set_idling(69, 31);
        test_random_traffic(80);
        test_ring_wrap();
        test_backpressure();

        set_idling(0, 0);
        test_random_traffic(80);
        test_long_channel();

        await_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wcmm_pkg.sv
rtl/wcmm_stream_if.sv
rtl/wcmm_ring.sv
rtl/wcmm_cfg.sv
rtl/windowed_channel_min_max_unit.sv
test/tb_windowed_channel_min_max_unit.sv
